// ----- sv/cabe_pkg.sv -----
// ----------------------------------------------------------------------------
// cabe_pkg
// Shared types, constants and the charge-curve table of the charge-aware
// battery level estimator.
// ----------------------------------------------------------------------------
package cabe_pkg;

   localparam int MV_W   = 13;
   localparam int PCT_W  = 7;
   localparam int TICK_W = 8;
   localparam int ROM_N  = 133;
   localparam int DIV_CNT_W = $clog2(MV_W);

   localparam logic [MV_W-1:0]  LOW_BAND_MV    = 13'd2100;
   localparam logic [MV_W-1:0]  MID_BAND_MV    = 13'd2300;
   localparam logic [MV_W-1:0]  BASE_MARGIN_MV = 13'd200;
   localparam logic [MV_W-1:0]  ADJ_JUMP_MV    = 13'd500;
   localparam logic [MV_W-1:0]  STEP_LOW_MV    = 13'd3001;
   localparam logic [MV_W-1:0]  STEP_MID_MV    = 13'd3300;
   localparam logic [MV_W-1:0]  STEP_HIGH_MV   = 13'd3652;
   localparam logic [MV_W-1:0]  SPAN_RECIP     = 13'd5243;
   localparam int               SPAN_SHIFT     = 19;
   localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;

   localparam logic [MV_W-1:0] CURVE_ROM [ROM_N] = '{
      13'd0, 13'd520, 13'd1260, 13'd1500, 13'd1520, 13'd1860, 13'd2400, 13'd2460,
      13'd2571, 13'd2635, 13'd2684, 13'd2726, 13'd2762, 13'd2796, 13'd2828, 13'd2863,
      13'd2893, 13'd2918, 13'd2946, 13'd2969, 13'd2993, 13'd3014, 13'd3033, 13'd3052,
      13'd3072, 13'd3090, 13'd3107, 13'd3123, 13'd3139, 13'd3155, 13'd3169, 13'd3185,
      13'd3198, 13'd3213, 13'd3226, 13'd3238, 13'd3251, 13'd3262, 13'd3274, 13'd3286,
      13'd3299, 13'd3310, 13'd3320, 13'd3331, 13'd3343, 13'd3352, 13'd3363, 13'd3372,
      13'd3382, 13'd3391, 13'd3400, 13'd3410, 13'd3418, 13'd3427, 13'd3436, 13'd3444,
      13'd3452, 13'd3460, 13'd3468, 13'd3476, 13'd3483, 13'd3492, 13'd3500, 13'd3505,
      13'd3513, 13'd3519, 13'd3526, 13'd3534, 13'd3539, 13'd3546, 13'd3551, 13'd3559,
      13'd3564, 13'd3570, 13'd3576, 13'd3580, 13'd3586, 13'd3591, 13'd3597, 13'd3601,
      13'd3607, 13'd3611, 13'd3616, 13'd3620, 13'd3625, 13'd3629, 13'd3633, 13'd3637,
      13'd3641, 13'd3645, 13'd3649, 13'd3652, 13'd3656, 13'd3660, 13'd3663, 13'd3666,
      13'd3669, 13'd3673, 13'd3675, 13'd3678, 13'd3682, 13'd3685, 13'd3687, 13'd3690,
      13'd3692, 13'd3695, 13'd3698, 13'd3700, 13'd3702, 13'd3705, 13'd3706, 13'd3708,
      13'd3711, 13'd3713, 13'd3716, 13'd3717, 13'd3719, 13'd3722, 13'd3722, 13'd3724,
      13'd3727, 13'd3728, 13'd3730, 13'd3732, 13'd3733, 13'd3735, 13'd3736, 13'd3737,
      13'd3739, 13'd3740, 13'd3741, 13'd3743, 13'd3743
   };

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_PREP      = 10'b00_0000_0010,
      S_ROUTE     = 10'b00_0000_0100,
      S_SEARCH    = 10'b00_0000_1000,
      S_CURVE     = 10'b00_0001_0000,
      S_REAL_GO   = 10'b00_0010_0000,
      S_REAL_WAIT = 10'b00_0100_0000,
      S_LVL_GO    = 10'b00_1000_0000,
      S_LVL_WAIT  = 10'b01_0000_0000,
      S_FINISH    = 10'b10_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      DIV_NONE = 2'd0,
      DIV_REAL = 2'd1,
      DIV_LVL  = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_go;
      logic        prep;
      logic        search;
      logic        curve;
      logic        real_take;
      logic        lvl_take;
      logic        finish;
      div_sel_type div_sel;
   } cmd_type;

   typedef struct packed {
      logic chg;
      logic need_curve;
      logic need_search;
      logic need_lvl;
      logic search_done;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [MV_W-1:0] rom_at(input logic [TICK_W-1:0] i);
      logic [MV_W-1:0] r;
      if (int'(i) < ROM_N) begin
         r = CURVE_ROM[i];
      end else begin
         r = CURVE_ROM[ROM_N-1];
      end
      return r;
   endfunction

endpackage

// ----- sv/cabe_div.sv -----
// ----------------------------------------------------------------------------
// cabe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cabe_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cabe_pkg::MV_W-1:0] num,
   input  logic [cabe_pkg::MV_W-1:0] den,
   output logic                      done,
   output logic [cabe_pkg::MV_W-1:0] quot
);

   localparam int W = cabe_pkg::MV_W;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [cabe_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                     rem_ff, rem_in;
   logic [W-1:0]                     quo_ff, quo_in;
   logic [W-1:0]                     den_ff, den_in;
   logic [W:0]                       shifted;
   logic                             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = cabe_pkg::DIV_CNT_W'(W-1);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? W'(shifted - {1'b0, den_ff}) : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- sv/cabe_ctrl.sv -----
// ----------------------------------------------------------------------------
// cabe_ctrl
// Sequencer of the estimator: accepts a request and steps the datapath.
// ----------------------------------------------------------------------------
module cabe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cabe_pkg::status_type   status,
   output cabe_pkg::cmd_type      cmd
);

   cabe_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = cabe_pkg::DIV_NONE;
      req_ready = 1'b0;
      case (state_ff)
         cabe_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cabe_pkg::S_PREP;
            end
         end
         cabe_pkg::S_PREP: begin
            cmd.prep = 1'b1;
            state_in = cabe_pkg::S_ROUTE;
         end
         cabe_pkg::S_ROUTE: begin
            if (status.need_search) begin
               state_in = cabe_pkg::S_SEARCH;
            end else if (status.need_curve) begin
               state_in = cabe_pkg::S_CURVE;
            end else if (status.chg) begin
               state_in = cabe_pkg::S_LVL_GO;
            end else begin
               state_in = cabe_pkg::S_REAL_GO;
            end
         end
         cabe_pkg::S_SEARCH: begin
            cmd.search = 1'b1;
            if (status.search_done) begin
               state_in = cabe_pkg::S_CURVE;
            end
         end
         cabe_pkg::S_CURVE: begin
            cmd.curve = 1'b1;
            state_in  = status.chg ? cabe_pkg::S_LVL_GO : cabe_pkg::S_REAL_GO;
         end
         cabe_pkg::S_REAL_GO: begin
            cmd.div_sel = cabe_pkg::DIV_REAL;
            cmd.div_go  = 1'b1;
            state_in    = cabe_pkg::S_REAL_WAIT;
         end
         cabe_pkg::S_REAL_WAIT: begin
            cmd.div_sel = cabe_pkg::DIV_REAL;
            if (status.div_done) begin
               cmd.real_take = 1'b1;
               state_in = status.need_lvl ? cabe_pkg::S_LVL_GO : cabe_pkg::S_FINISH;
            end
         end
         cabe_pkg::S_LVL_GO: begin
            cmd.div_sel = cabe_pkg::DIV_LVL;
            cmd.div_go  = 1'b1;
            state_in    = cabe_pkg::S_LVL_WAIT;
         end
         cabe_pkg::S_LVL_WAIT: begin
            cmd.div_sel = cabe_pkg::DIV_LVL;
            if (status.div_done) begin
               cmd.lvl_take = 1'b1;
               state_in     = cabe_pkg::S_FINISH;
            end
         end
         cabe_pkg::S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = cabe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cabe_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cabe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/cabe_dp.sv -----
// ----------------------------------------------------------------------------
// cabe_dp
// Datapath: estimator state, curve scan, percent conversion, result register.
// ----------------------------------------------------------------------------
module cabe_dp #(
   parameter int CURVE_ENTRIES    = 133,
   parameter int SETTLE_SAMPLES   = 30,
   parameter int MAX_CHARGE_TICKS = 168
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cabe_pkg::cmd_type           cmd,
   output cabe_pkg::status_type        status,
   input  logic [cabe_pkg::MV_W-1:0]   req_sample_mv,
   input  logic                        req_on_charger,
   input  logic [cabe_pkg::MV_W-1:0]   empty_mv,
   input  logic [cabe_pkg::MV_W-1:0]   full_mv,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [cabe_pkg::PCT_W-1:0]  rsp_level_pct,
   output logic                        rsp_charging_out
);

   localparam int MW = cabe_pkg::MV_W;
   localparam int PW = cabe_pkg::PCT_W;
   localparam int TW = cabe_pkg::TICK_W;
   localparam logic [TW-1:0] LAST_IDX  = TW'(CURVE_ENTRIES - 1);
   localparam logic [4:0]    SETTLE    = 5'(SETTLE_SAMPLES);
   localparam logic [TW-1:0] MAX_TICKS = TW'(MAX_CHARGE_TICKS);

   logic [MW-1:0] v_ff, v_in;
   logic          chg_ff, chg_in;
   logic [MW-1:0] step_ff, step_in;
   logic [MW-1:0] cv_ff, cv_in;
   logic [PW-1:0] real_ff, real_in;
   logic [PW-1:0] lvl_ff, lvl_in;
   logic [TW-1:0] scan_ff, scan_in;
   logic          need_curve_ff, need_curve_in;
   logic          settle_path_ff, settle_path_in;
   logic [MW-1:0] baseline_ff, baseline_in;
   logic          adj_pend_ff, adj_pend_in;
   logic [MW-1:0] adj_ref_ff, adj_ref_in;
   logic [TW-1:0] ticks_ff, ticks_in;
   logic [4:0]    settle_ff, settle_in;
   logic [TW-1:0] start_ff, start_in;
   logic          start_valid_ff, start_valid_in;
   logic [1:0]    tstep_ff, tstep_in;
   logic [PW-1:0] saved_ff, saved_in;
   logic [PW-1:0] est_ff, est_in;
   logic signed [7:0] ease_ff, ease_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_level_ff, rsp_level_in;
   logic          rsp_chg_ff, rsp_chg_in;

   logic [MW-1:0] div_num, div_den, div_q;
   logic          div_done;

   logic [MW-1:0]   span, span_q;
   logic [2*MW-1:0] span_prod;
   logic [MW-1:0] pct_x;
   logic          pct_incl;
   logic [PW-1:0] pct_val;
   logic [MW-1:0] rom_t, rom_p, cv_rom;
   logic          hit, last;
   logic [TW:0]   idx_sum;
   logic [TW-1:0] idx;
   logic [1:0]    tstep_new;
   logic signed [9:0] est10, real10, diff10, mul10, lvl_pos, lvl_neg, qs10;
   logic [6:0]    mag7, q7;
   logic [14:0]   prod;
   logic          step3;
   logic [PW-1:0] eased, lo, hi;
   logic signed [7:0] d8;
   logic          out_free;

   function automatic logic [PW-1:0] clamp10(input logic signed [9:0] x);
      logic [PW-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > 10'sd100) begin
         r = cabe_pkg::PCT_FULL;
      end else begin
         r = x[PW-1:0];
      end
      return r;
   endfunction

   cabe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      span      = full_mv - empty_mv;
      span_prod = {{MW{1'b0}}, span} * {{MW{1'b0}}, cabe_pkg::SPAN_RECIP};
      span_q    = MW'(span_prod >> cabe_pkg::SPAN_SHIFT);
   end

   always_comb begin
      case (cmd.div_sel)
         cabe_pkg::DIV_REAL: begin
            div_num = v_ff - empty_mv;
            div_den = step_ff;
         end
         cabe_pkg::DIV_LVL: begin
            div_num = cv_ff - empty_mv;
            div_den = step_ff;
         end
         default: begin
            div_num = '0;
            div_den = MW'(1);
         end
      endcase
   end

   always_comb begin
      pct_x    = (cmd.div_sel == cabe_pkg::DIV_REAL) ? v_ff : cv_ff;
      pct_incl = chg_ff && (cmd.div_sel == cabe_pkg::DIV_LVL);
      if (pct_incl ? (pct_x >= full_mv) : (pct_x > full_mv)) begin
         pct_val = cabe_pkg::PCT_FULL;
      end else if (pct_x <= empty_mv) begin
         pct_val = '0;
      end else if (div_q > MW'(cabe_pkg::PCT_FULL)) begin
         pct_val = cabe_pkg::PCT_FULL;
      end else begin
         pct_val = div_q[PW-1:0];
      end
   end

   always_comb begin
      rom_t = cabe_pkg::rom_at(scan_ff);
      rom_p = cabe_pkg::rom_at(scan_ff - 1'b1);
      hit   = baseline_ff <= rom_t;
      last  = scan_ff == LAST_IDX;
      idx_sum = {1'b0, start_ff} + {1'b0, ticks_ff};
      idx   = (idx_sum >= (TW+1)'(CURVE_ENTRIES)) ? LAST_IDX : idx_sum[TW-1:0];
      cv_rom = cabe_pkg::rom_at(idx);
      if (cv_rom < cabe_pkg::STEP_LOW_MV) begin
         tstep_new = 2'd1;
      end else if (cv_rom < cabe_pkg::STEP_MID_MV) begin
         tstep_new = 2'd2;
      end else if (cv_rom < cabe_pkg::STEP_HIGH_MV) begin
         tstep_new = 2'd3;
      end else begin
         tstep_new = 2'd2;
      end
   end

   always_comb begin
      est10  = signed'({3'b000, est_ff});
      real10 = signed'({3'b000, real_ff});
      diff10 = signed'({3'b000, saved_ff}) - real10;
      step3  = (ease_ff > 8'sd10) || (ease_ff < -8'sd10);
      mul10  = (diff10 <<< 1) + (step3 ? diff10 : 10'sd0);
      lvl_pos = est10 - mul10;
      mag7   = diff10 < 0 ? 7'(-diff10) : diff10[6:0];
      prod   = 15'(mag7) * 15'd171;
      q7     = step3 ? 7'(prod >> 9) : (mag7 >> 1);
      qs10   = signed'({3'b000, q7});
      lvl_neg = est10 - ((diff10 < 0) ? -qs10 : qs10);
      if (ease_ff > 0) begin
         eased = clamp10(lvl_pos);
         lo    = real_ff;
         hi    = eased;
      end else begin
         eased = clamp10(lvl_neg);
         lo    = eased;
         hi    = real_ff;
      end
      d8 = signed'({1'b0, real_ff}) - signed'({1'b0, est_ff});
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      v_in = v_ff;  chg_in = chg_ff;  step_in = step_ff;  cv_in = cv_ff;
      real_in = real_ff;  lvl_in = lvl_ff;  scan_in = scan_ff;
      need_curve_in = need_curve_ff;  settle_path_in = settle_path_ff;
      baseline_in = baseline_ff;  adj_pend_in = adj_pend_ff;  adj_ref_in = adj_ref_ff;
      ticks_in = ticks_ff;  settle_in = settle_ff;  start_in = start_ff;
      start_valid_in = start_valid_ff;  tstep_in = tstep_ff;  saved_in = saved_ff;
      est_in = est_ff;  ease_in = ease_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_level_in = rsp_level_ff;  rsp_chg_in = rsp_chg_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         v_in    = req_sample_mv;
         chg_in  = req_on_charger;
         scan_in = '0;
         step_in = (span_q == '0) ? MW'(1) : span_q;
      end
      if (cmd.prep) begin
         if (chg_ff) begin
            settle_in = '0;
            ease_in   = '0;
            if (baseline_ff == '0) begin
               adj_pend_in = 1'b1;
               adj_ref_in  = v_ff;
               if (v_ff < cabe_pkg::LOW_BAND_MV) begin
                  baseline_in = cabe_pkg::rom_at(TW'(0));
               end else if (v_ff < cabe_pkg::MID_BAND_MV) begin
                  baseline_in = cabe_pkg::rom_at(TW'(2));
               end else begin
                  baseline_in = v_ff - cabe_pkg::BASE_MARGIN_MV;
                  adj_pend_in = 1'b0;
               end
            end else if (adj_pend_ff) begin
               if ((v_ff < adj_ref_ff) || ((v_ff - adj_ref_ff) > cabe_pkg::ADJ_JUMP_MV)) begin
                  baseline_in = (baseline_ff == cabe_pkg::LOW_BAND_MV) ?
                                cabe_pkg::rom_at(TW'(2)) : cabe_pkg::rom_at(TW'(6));
                  start_valid_in = 1'b0;
                  adj_pend_in    = 1'b0;
               end
            end
            need_curve_in  = ticks_ff < MAX_TICKS;
            settle_path_in = 1'b0;
            if (ticks_ff >= MAX_TICKS) begin
               cv_in = full_mv;
            end
         end else begin
            settle_path_in = (settle_ff < SETTLE) && (ticks_ff != '0);
            need_curve_in  = (settle_ff < SETTLE) && (ticks_ff != '0);
         end
      end
      if (cmd.search) begin
         if (hit || last) begin
            start_valid_in = 1'b1;
            scan_in        = '0;
            if (hit && (scan_ff != '0)) begin
               start_in = ((baseline_ff - rom_p) <= (rom_t - baseline_ff)) ?
                          scan_ff - 1'b1 : scan_ff;
            end else begin
               start_in = '0;
            end
         end else begin
            scan_in = scan_ff + 1'b1;
         end
      end
      if (cmd.curve) begin
         cv_in    = cv_rom;
         tstep_in = tstep_new;
         if (chg_ff) begin
            ticks_in = ticks_ff + TW'(tstep_new);
         end
      end
      if (cmd.real_take) begin
         real_in = pct_val;
      end
      if (cmd.lvl_take) begin
         lvl_in = pct_val;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_chg_in   = chg_ff;
         if (chg_ff) begin
            rsp_level_in = lvl_ff;
            est_in       = lvl_ff;
         end else if (settle_path_ff) begin
            settle_in = settle_ff + 1'b1;
            if ((settle_ff + 1'b1 == SETTLE) && ((d8 > 8'sd1) || (d8 < -8'sd1))) begin
               ease_in  = signed'({1'b0, est_ff}) - signed'({1'b0, real_ff});
               saved_in = real_ff;
            end else begin
               ease_in = '0;
            end
            rsp_level_in = lvl_ff;
            est_in       = lvl_ff;
         end else begin
            start_valid_in = 1'b0;
            ticks_in       = '0;
            baseline_in    = v_ff;
            if (ease_ff != '0) begin
               if (hi <= lo) begin
                  rsp_level_in = real_ff;
                  ease_in      = '0;
                  saved_in     = real_ff;
               end else begin
                  rsp_level_in = eased;
               end
            end else begin
               rsp_level_in = real_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff    <= '0;
         adj_pend_ff    <= 1'b0;
         adj_ref_ff     <= '0;
         ticks_ff       <= '0;
         settle_ff      <= '0;
         start_ff       <= '0;
         start_valid_ff <= 1'b0;
         tstep_ff       <= 2'd1;
         saved_ff       <= '0;
         est_ff         <= '0;
         ease_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_ff        <= '0;
      end else begin
         baseline_ff    <= baseline_in;
         adj_pend_ff    <= adj_pend_in;
         adj_ref_ff     <= adj_ref_in;
         ticks_ff       <= ticks_in;
         settle_ff      <= settle_in;
         start_ff       <= start_in;
         start_valid_ff <= start_valid_in;
         tstep_ff       <= tstep_in;
         saved_ff       <= saved_in;
         est_ff         <= est_in;
         ease_ff        <= ease_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_ff        <= scan_in;
      end
      v_ff           <= v_in;
      chg_ff         <= chg_in;
      step_ff        <= step_in;
      cv_ff          <= cv_in;
      real_ff        <= real_in;
      lvl_ff         <= lvl_in;
      need_curve_ff  <= need_curve_in;
      settle_path_ff <= settle_path_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_chg_ff     <= rsp_chg_in;
   end

   always_comb begin
      status.chg         = chg_ff;
      status.need_curve  = need_curve_ff;
      status.need_search = need_curve_ff && !start_valid_ff;
      status.need_lvl    = chg_ff || settle_path_ff;
      status.search_done = hit || last;
      status.div_done    = div_done;
      status.out_free    = out_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level_pct    = rsp_level_ff;
   assign rsp_charging_out = rsp_chg_ff;

   a_level_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= cabe_pkg::PCT_FULL)
      else $error("level above full scale");
   a_est_range : assert property (@(posedge clock) disable iff (reset)
      est_ff <= cabe_pkg::PCT_FULL)
      else $error("estimate above full scale");
   a_settle_range : assert property (@(posedge clock) disable iff (reset)
      settle_ff <= SETTLE)
      else $error("settle count overrun");
   a_finish_free : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result overwritten");

endmodule

// ----- sv/charge_aware_battery_level_estimator_top.sv -----
// ----------------------------------------------------------------------------
// charge_aware_battery_level_estimator_top
// Steps: prep, route, an optional curve scan and curve lookup, then
// one or two divisions on the shared divider, one when unplugged
// outside the settle window or when charging, two in the settle
// window. One request at a time; the next request is taken the cycle
// after the result is loaded, while it waits.
// Reset (synchronous, active high) restores the register defaults and state.
// ----------------------------------------------------------------------------
module charge_aware_battery_level_estimator_top #(
   parameter int CURVE_ENTRIES    = 133,
   parameter int SETTLE_SAMPLES   = 30,
   parameter int MAX_CHARGE_TICKS = 168
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cabe_pkg::MV_W-1:0]   req_sample_mv,
   input  logic                        req_on_charger,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cabe_pkg::PCT_W-1:0]  rsp_level_pct,
   output logic                        rsp_charging_out,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int MW = cabe_pkg::MV_W;

   logic [MW-1:0] empty_ff, empty_in;
   logic [MW-1:0] full_ff, full_in;
   logic          wr;
   cabe_pkg::cmd_type    cmd;
   cabe_pkg::status_type status;

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      empty_in = empty_ff;
      full_in  = full_ff;
      if (wr) begin
         if (csr_paddr[2]) begin
            full_in = csr_pwdata[MW-1:0];
         end else begin
            empty_in = csr_pwdata[MW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 13'd3000;
         full_ff  <= 13'd4100;
      end else begin
         empty_ff <= empty_in;
         full_ff  <= full_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? {19'd0, full_ff} : {19'd0, empty_ff};
   assign csr_pready = 1'b1;

   cabe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cabe_dp #(
      .CURVE_ENTRIES    (CURVE_ENTRIES),
      .SETTLE_SAMPLES   (SETTLE_SAMPLES),
      .MAX_CHARGE_TICKS (MAX_CHARGE_TICKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_mv    (req_sample_mv),
      .req_on_charger   (req_on_charger),
      .empty_mv         (empty_ff),
      .full_mv          (full_ff),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_level_pct    (rsp_level_pct),
      .rsp_charging_out (rsp_charging_out)
   );

endmodule
